// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the bit-addressed field store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is held.
`define BAFS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define BAFS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/bafs_pkg.sv
// ----------------------------------------------------------------------------
// bafs_pkg
// Types and constants of the bit-addressed field store.
// ----------------------------------------------------------------------------
package bafs_pkg;

	// default number of 32-bit words in the store
	localparam int STORE_WORDS_DEF = 32;

	// field widths
	localparam int WORD_W = 32;
	localparam int IDX_W  = 10;
	localparam int FWID_W = 6;
	localparam int CFG_W  = 6;
	localparam int ACT_W  = 3;
	localparam int OFS_W  = 5;
	localparam int SLOT_W = IDX_W - OFS_W;

	// words reachable by a bit index
	localparam int SLOT_LIMIT = 1 << SLOT_W;
	// largest value the word-count register can hold
	localparam int CFG_MAX = (1 << CFG_W) - 1;
	// word count after reset
	localparam int WIU_RESET = 32;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ_BIT    = 3'd0,
		ACT_SET_BIT     = 3'd1,
		ACT_CLEAR_BIT   = 3'd2,
		ACT_TOGGLE_BIT  = 3'd3,
		ACT_WRITE_BIT   = 3'd4,
		ACT_READ_FIELD  = 3'd5,
		ACT_WRITE_FIELD = 3'd6,
		ACT_NOP         = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_READ  = 3'd1,
		ST_EXEC  = 3'd2,
		ST_WR_HI = 3'd3,
		ST_DONE  = 3'd4
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic rd;
		logic wr_lo;
		logic wr_hi;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_wr_lo;
		logic need_wr_hi;
		logic out_free;
	} sts_t;

endpackage

// File: src/bafs_if.sv
// ----------------------------------------------------------------------------
// bafs_req_if / bafs_rsp_if
// Valid/ready channels carrying store requests and their results.
// ----------------------------------------------------------------------------
interface bafs_req_if;
	logic                         valid;
	logic                         ready;
	logic [bafs_pkg::ACT_W-1:0]   action;
	logic [bafs_pkg::IDX_W-1:0]   bit_index;
	logic [bafs_pkg::FWID_W-1:0]  field_width;
	logic [bafs_pkg::WORD_W-1:0]  write_value;

	modport source (output valid, action, bit_index, field_width, write_value, input ready);
	modport sink   (input valid, action, bit_index, field_width, write_value, output ready);
endinterface

interface bafs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bafs_pkg::WORD_W-1:0]  read_data;
	logic                         out_of_range;

	modport source (output valid, read_data, out_of_range, input ready);
	modport sink   (input valid, read_data, out_of_range, output ready);
endinterface

// File: src/bafs_datapath.sv
// ----------------------------------------------------------------------------
// bafs_datapath
// Word memory, request and result registers, and the bit/field shift logic.
// ----------------------------------------------------------------------------
module bafs_datapath #(
	parameter int STORE_WORDS = bafs_pkg::STORE_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bafs_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic [bafs_pkg::ACT_W-1:0]   action,
	input  logic [bafs_pkg::IDX_W-1:0]   bit_index,
	input  logic [bafs_pkg::FWID_W-1:0]  field_width,
	input  logic [bafs_pkg::WORD_W-1:0]  write_value,
	input  bafs_pkg::cmd_t               cmd,
	output bafs_pkg::sts_t               sts,
	input  logic                         rsp_ready,
	output logic                         rsp_valid,
	output logic [bafs_pkg::WORD_W-1:0]  read_data,
	output logic                         out_of_range
);
	import bafs_pkg::*;

	// a bit index reaches SLOT_LIMIT words; a field at the last one spills into one more
	localparam int MEM_DEPTH = (STORE_WORDS < SLOT_LIMIT + 1) ? STORE_WORDS : SLOT_LIMIT + 1;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [CFG_W-1:0] LIVE_CAP =
		(STORE_WORDS > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(STORE_WORDS);

	logic [CFG_W-1:0]      wiu_q;
	action_t               action_q;
	logic [IDX_W-1:0]      idx_q;
	logic [FWID_W-1:0]     width_q;
	logic [WORD_W-1:0]     wval_q;
	logic [WORD_W-1:0]     mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0]     lo_q;
	logic [WORD_W-1:0]     hi_q;
	logic [WORD_W-1:0]     rd_data_q;
	logic                  oor_q;
	logic                  out_valid_q;

	logic [CFG_W-1:0]      live;
	logic [SLOT_W-1:0]     slot;
	logic [OFS_W-1:0]      ofs;
	logic [CFG_W-1:0]      slot_ext;
	logic [CFG_W-1:0]      slot_nx;
	logic [AW-1:0]         addr_lo;
	logic [AW-1:0]         addr_hi;
	logic                  is_field;
	logic                  bad_width;
	logic                  oor;
	logic                  has_next;
	logic [WORD_W-1:0]     mask;
	logic [WORD_W-1:0]     bit1;
	logic [2*WORD_W-1:0]   cat;
	logic [2*WORD_W-1:0]   shifted;
	logic [2*WORD_W-1:0]   fmask;
	logic [2*WORD_W-1:0]   fval;
	logic [WORD_W-1:0]     new_lo;
	logic [WORD_W-1:0]     new_hi;
	logic [WORD_W-1:0]     rd_val;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [WORD_W-1:0]     wr_data;

	// word-count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= CFG_W'(WIU_RESET);
		end else if (cfg_we) begin
			wiu_q <= cfg_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action_t'(action);
			idx_q    <= bit_index;
			width_q  <= field_width;
			wval_q   <= write_value;
		end
	end

	// range checks
	always_comb begin
		live      = (wiu_q > LIVE_CAP) ? LIVE_CAP : wiu_q;
		slot      = idx_q[IDX_W-1:OFS_W];
		ofs       = idx_q[OFS_W-1:0];
		slot_ext  = {1'b0, slot};
		slot_nx   = slot_ext + CFG_W'(1);
		addr_lo   = slot_ext[AW-1:0];
		addr_hi   = slot_nx[AW-1:0];
		is_field  = (action_q == ACT_READ_FIELD) || (action_q == ACT_WRITE_FIELD);
		bad_width = (width_q == '0) || (width_q > FWID_W'(WORD_W));
		oor       = (action_q != ACT_NOP) &&
			((slot_ext >= live) || (is_field && bad_width));
		has_next  = (ofs != '0) && (slot_nx < live);
	end

	// shift and mask logic over the two fetched words
	always_comb begin
		mask    = (width_q >= FWID_W'(WORD_W)) ? '1 :
			((WORD_W'(1) << width_q) - WORD_W'(1));
		bit1    = WORD_W'(1) << ofs;
		cat     = {(has_next ? hi_q : '0), lo_q};
		shifted = cat >> ofs;
		fmask   = {{WORD_W{1'b0}}, mask} << ofs;
		fval    = {{WORD_W{1'b0}}, wval_q & mask} << ofs;
		new_hi  = (hi_q & ~fmask[2*WORD_W-1:WORD_W]) | fval[2*WORD_W-1:WORD_W];
		case (action_q)
			ACT_SET_BIT:     new_lo = lo_q | bit1;
			ACT_CLEAR_BIT:   new_lo = lo_q & ~bit1;
			ACT_TOGGLE_BIT:  new_lo = lo_q ^ bit1;
			ACT_WRITE_BIT:   new_lo = wval_q[0] ? (lo_q | bit1) : (lo_q & ~bit1);
			ACT_WRITE_FIELD: new_lo = (lo_q & ~fmask[WORD_W-1:0]) | fval[WORD_W-1:0];
			default:         new_lo = lo_q;
		endcase
		case (action_q)
			ACT_READ_BIT:   rd_val = {{(WORD_W-1){1'b0}}, lo_q[ofs]};
			ACT_READ_FIELD: rd_val = shifted[WORD_W-1:0] & mask;
			default:        rd_val = '0;
		endcase
	end

	// write port: low word first, high word in the next cycle
	always_comb begin
		wr_en   = cmd.wr_lo || cmd.wr_hi;
		wr_addr = cmd.wr_hi ? addr_hi : addr_lo;
		wr_data = cmd.wr_hi ? new_hi : new_lo;
	end

	// per-word valid bits: an unwritten word reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// word memory, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			lo_q <= valid_q[addr_lo] ? mem[addr_lo] : '0;
			hi_q <= valid_q[addr_hi] ? mem[addr_hi] : '0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rd_data_q <= oor ? '0 : rd_val;
			oor_q     <= oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// status to controller
	always_comb begin
		sts.need_wr_lo = !oor && (action_q == ACT_SET_BIT || action_q == ACT_CLEAR_BIT ||
			action_q == ACT_TOGGLE_BIT || action_q == ACT_WRITE_BIT ||
			action_q == ACT_WRITE_FIELD);
		sts.need_wr_hi = !oor && (action_q == ACT_WRITE_FIELD) && has_next;
		sts.out_free   = !out_valid_q || rsp_ready;
	end

	assign rsp_valid    = out_valid_q;
	assign read_data    = rd_data_q;
	assign out_of_range = oor_q;

endmodule

// File: src/bafs_ctrl.sv
// ----------------------------------------------------------------------------
// bafs_ctrl
// Sequencer: capture, fetch, modify, optional second write, hand off result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bafs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  bafs_pkg::sts_t  sts,
	output bafs_pkg::cmd_t  cmd
);
	import bafs_pkg::*;

	state_t state_q;
	state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (req_valid) state_nx = ST_READ;
			ST_READ:  state_nx = ST_EXEC;
			ST_EXEC:  state_nx = sts.need_wr_hi ? ST_WR_HI : ST_DONE;
			ST_WR_HI: state_nx = ST_DONE;
			ST_DONE:  if (sts.out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_READ:  cmd.rd       = 1'b1;
			ST_EXEC:  cmd.wr_lo    = sts.need_wr_lo;
			ST_WR_HI: cmd.wr_hi    = 1'b1;
			ST_DONE:  cmd.load_out = sts.out_free;
			default: begin
				cmd       = '0;
				req_ready = 1'b0;
			end
		endcase
	end

	`BAFS_ASSERT(a_hi_follows_lo, clk, arst_n, cmd.wr_hi |-> $past(cmd.wr_lo), "high-word write without low-word write")
	`BAFS_ASSERT(a_capture_then_read, clk, arst_n, cmd.capture |=> cmd.rd, "captured request not fetched next cycle")
	`BAFS_ASSERT_NEVER(a_load_into_full, clk, arst_n, cmd.load_out && !sts.out_free, "result loaded over a pending one")

endmodule

// File: src/bit_addressed_field_store.sv
// ----------------------------------------------------------------------------
// bit_addressed_field_store
// Bit array in 32-bit words with single-bit and unaligned field access.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  ---------+-----+-------------------------------------------------------
//  req      | in  | action, bit_index, field_width, write_value
//  rsp      | out | read_data, out_of_range (one per request)
//  cfg      | in  | cfg_we / cfg_wdata: words in use
//
//  A result is loaded after the fetch and the modify step, and after a second
//  write for a field write spanning two words (one memory write port); the next
//  request is taken only after that, so requests are never overlapped.
//  Reset clears the store at once through per-word valid bits.
//  A result waiting on rsp does not block acceptance; the sequencer only
//  stalls when a new result is ready while the previous one is still held.
// ----------------------------------------------------------------------------
module bit_addressed_field_store #(
	parameter int STORE_WORDS = bafs_pkg::STORE_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bafs_pkg::CFG_W-1:0]  cfg_wdata,
	bafs_req_if.sink                    req,
	bafs_rsp_if.source                  rsp
);
	import bafs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bafs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bafs_datapath #(
		.STORE_WORDS (STORE_WORDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.action       (req.action),
		.bit_index    (req.bit_index),
		.field_width  (req.field_width),
		.write_value  (req.write_value),
		.cmd          (cmd),
		.sts          (sts),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.read_data    (rsp.read_data),
		.out_of_range (rsp.out_of_range)
	);

endmodule
